// ===== hdl/temh_pkg.sv =====
// Shared types and constants of the timed event min-heap core.
package temh_pkg;

  localparam int Capacity = 64;
  localparam int TagBits = 16;
  localparam int PosW = $clog2(Capacity + 1);
  localparam int SlotW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int SecW = 33;
  localparam int UsecW = 20;
  localparam logic [UsecW:0] UsecPerSec = 21'd1000000;

  // Packed heap entry: tag, due seconds, due microseconds.
  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [UsecW-1:0] usec;
    logic [15:0]      tag;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;      // capture the request; a tick also stores the current time
    logic append;       // grow the heap and open a hole at its end
    logic up_rd;        // read the parent of the hole
    logic up_step;      // move the parent down or drop the new entry into the hole
    logic pop_last;     // shrink the heap and read its last entry
    logic dn_rd;        // read both children of the hole
    logic dn_step;      // move the smaller child up or drop the entry into the hole
    logic root_rd;      // read the root
    logic out_load;     // capture a result from the root
    logic out_full;     // capture a queue full result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic full;
    logic empty;
    logic up_move;
    logic dn_move;
    logic expired;
  } stat_t;

  // Strict ordering of due times.
  function automatic logic earlier(input entry_t a, input entry_t b);
    earlier = (a.sec < b.sec) || ((a.sec == b.sec) && (a.usec < b.usec));
  endfunction

endpackage

// ===== hdl/timed_event_min_heap_core.sv =====
// Top level of the timed event min-heap core.
// Timer queue of up to 64 events held as a binary min-heap ordered by due time.
// A schedule request computes its due time from the last tick time and sifts up,
// reading the parent of the hole and then moving it down or dropping the new entry
// in, level by level; a full queue returns one result with status 1. A tick request
// stores the time and pops every event due strictly earlier: each pop takes a root
// check, a read of the last entry, a sift-down level by level and a look at the new
// root to decide tlast. Results of a request are presented one at a time; a request
// that yields results is not finished until its final result (tlast high) is taken.
module timed_event_min_heap_core
  import temh_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // func
  input  logic          s_tuser,
  // delay_sec, delay_usec, event_tag, now_sec, now_usec, zero pad
  input  logic [119:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // status
  output logic          m_tuser,
  // fired_tag, due_sec, due_usec, zero pad
  output logic [71:0]   m_tdata,
  output logic          m_tlast
);

  cmd_t   cmd;
  stat_t  stat;
  logic   res_status;
  entry_t res_entry;

  temh_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
    .cmd(cmd), .stat(stat)
  );

  temh_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_func(s_tuser), .in_osec(s_tdata[30:0]), .in_ousec(s_tdata[50:31]),
    .in_tag(s_tdata[66:51]), .in_nsec(s_tdata[98:67]), .in_nusec(s_tdata[118:99]),
    .res_status(res_status), .res_entry(res_entry)
  );

  assign m_tuser = res_status;
  assign m_tdata = {3'b0, res_entry.usec, res_entry.sec, res_entry.tag};

endmodule

// ===== hdl/temh_datapath.sv =====
// Heap storage, due time arithmetic and sift datapath.
module temh_datapath
  import temh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        in_func,
  input  logic [30:0] in_osec,
  input  logic [19:0] in_ousec,
  input  logic [15:0] in_tag,
  input  logic [31:0] in_nsec,
  input  logic [19:0] in_nusec,
  output logic        res_status,
  output entry_t      res_entry
);

  entry_t heap [Capacity];
  logic [PosW-1:0] count;
  logic [31:0] current_sec;
  logic [19:0] current_usec;
  logic [PosW-1:0] pos;
  logic is_tick;
  entry_t new_entry;
  entry_t rd_a, rd_b, rd_c;
  logic [30:0] osec;
  logic [UsecW:0] usum;
  logic [15:0] tag;

  // Sum of microseconds fits in 21 bits; carry is 0, 1 or 2.
  logic [UsecW:0] usum_m1, usum_m2;
  logic [1:0] carry;
  logic [UsecW-1:0] dusec;
  always_comb begin
    usum_m1 = usum - UsecPerSec;
    usum_m2 = usum - {UsecPerSec[UsecW-1:0], 1'b0};
    if (usum >= {UsecPerSec[UsecW-1:0], 1'b0}) begin
      carry = 2'd2;
      dusec = usum_m2[UsecW-1:0];
    end else if (usum >= UsecPerSec) begin
      carry = 2'd1;
      dusec = usum_m1[UsecW-1:0];
    end else begin
      carry = 2'd0;
      dusec = usum[UsecW-1:0];
    end
    new_entry.sec = {1'b0, current_sec} + {2'b0, osec} + {31'd0, carry};
    new_entry.usec = dusec;
    new_entry.tag = tag;
  end

  // Slot addresses for parent and children of the current position.
  logic [PosW-1:0] par;
  logic [PosW:0] lpos, rpos;
  logic pick_r, l_ok, r_ok;
  entry_t best;
  always_comb begin
    par = pos >> 1;
    lpos = {pos, 1'b0};
    rpos = {pos, 1'b1};
    l_ok = lpos <= {1'b0, count};
    r_ok = rpos <= {1'b0, count};
    pick_r = r_ok && earlier(rd_c, rd_b);
    best = pick_r ? rd_c : rd_b;
  end

  // The new entry rises past a later parent; the moved entry sinks below an earlier child.
  logic up_move, dn_move;
  assign up_move = (pos > PosW'(1)) && earlier(new_entry, rd_b);
  assign dn_move = l_ok && earlier(best, rd_a);

  // Heap storage with registered reads and one write per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      is_tick <= in_func;
      osec <= in_osec;
      usum <= {1'b0, current_usec} + {1'b0, in_ousec};
      tag <= in_tag & 16'((17'd1 << TagBits) - 17'd1);
    end
    if (cmd.up_rd) rd_b <= heap[SlotW'(par - 1'b1)];
    if (cmd.dn_rd) begin
      rd_b <= heap[SlotW'(lpos - 1'b1)];
      rd_c <= heap[SlotW'(rpos - 1'b1)];
    end
    if (cmd.root_rd) rd_a <= heap[SlotW'(0)];
    if (cmd.pop_last) rd_a <= heap[SlotW'(count - 1'b1)];
    if (cmd.up_step) heap[SlotW'(pos - 1'b1)] <= up_move ? rd_b : new_entry;
    if (cmd.dn_step) heap[SlotW'(pos - 1'b1)] <= dn_move ? best : rd_a;
    if (cmd.out_load) begin
      res_status <= 1'b0;
      res_entry <= rd_a;
    end
    if (cmd.out_full) begin
      res_status <= 1'b1;
      res_entry <= new_entry;
    end
  end

  // Position, count and current time.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      current_sec <= '0;
      current_usec <= '0;
      pos <= '0;
    end else begin
      if (cmd.load_in && in_func) begin
        current_sec <= in_nsec;
        current_usec <= in_nusec;
      end
      if (cmd.append) begin
        count <= count + 1'b1;
        pos <= count + 1'b1;
      end
      if (cmd.up_step) pos <= par;
      if (cmd.pop_last) begin
        count <= count - 1'b1;
        pos <= PosW'(1);
      end
      if (cmd.dn_step) pos <= pick_r ? rpos[PosW-1:0] : lpos[PosW-1:0];
    end
  end

  always_comb begin
    stat.is_tick = is_tick;
    stat.full = count >= PosW'(Capacity);
    stat.empty = count == '0;
    stat.up_move = up_move;
    stat.dn_move = dn_move;
    stat.expired = ({1'b0, current_sec} > rd_a.sec) ||
                   (({1'b0, current_sec} == rd_a.sec) &&
                    (current_usec > rd_a.usec));
  end

endmodule

// ===== hdl/temh_ctrl.sv =====
// Controller state machine of the timed event min-heap core.
module temh_ctrl
  import temh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  out_last,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [3:0] {
    IDLE, DECODE, UP_RD, UP_STEP, ROOT_CHK, POP, DN_RD, DN_STEP, ROOT_RD, LAST_CHK,
    SEND
  } state_t;

  state_t state;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd = '0;
    cmd.load_in = (state == IDLE) && in_valid;
    unique case (state)
      DECODE: begin
        if (stat.is_tick) begin
          cmd.root_rd = 1'b1;
        end else if (stat.full) begin
          cmd.out_full = 1'b1;
        end else begin
          cmd.append = 1'b1;
        end
      end
      UP_RD: cmd.up_rd = 1'b1;
      UP_STEP: cmd.up_step = 1'b1;
      ROOT_CHK: cmd.out_load = !stat.empty && stat.expired;
      POP: cmd.pop_last = 1'b1;
      DN_RD: cmd.dn_rd = 1'b1;
      DN_STEP: cmd.dn_step = 1'b1;
      ROOT_RD: cmd.root_rd = 1'b1;
      default: ;
    endcase
  end

  // State and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      out_last <= 1'b0;
    end else begin
      unique case (state)
        IDLE: if (in_valid) state <= DECODE;
        DECODE: begin
          if (stat.is_tick) state <= ROOT_CHK;
          else if (stat.full) begin
            out_valid <= 1'b1;
            out_last <= 1'b1;
            state <= SEND;
          end else state <= UP_RD;
        end
        UP_RD: state <= UP_STEP;
        UP_STEP: state <= stat.up_move ? UP_RD : IDLE;
        ROOT_CHK: begin
          if (!stat.empty && stat.expired) state <= POP;
          else state <= IDLE;
        end
        POP: state <= DN_RD;
        DN_RD: state <= DN_STEP;
        DN_STEP: state <= stat.dn_move ? DN_RD : ROOT_RD;
        ROOT_RD: state <= LAST_CHK;
        // The result is the final one when the heap is empty or the new root is not due yet.
        LAST_CHK: begin
          out_valid <= 1'b1;
          out_last <= !(!stat.empty && stat.expired);
          state <= SEND;
        end
        SEND: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= out_last ? IDLE : ROOT_CHK;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== sim/timed_event_min_heap_core_tb.sv =====
// Testbench of the timed event min-heap core: directed and random schedule and tick requests.
`timescale 1ns / 100ps

module timed_event_min_heap_core_tb
  import temh_pkg::*;
();

  localparam logic FUNC_SCHED = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam logic ST_FIRED = 1'b0;
  localparam logic ST_FULL = 1'b1;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic        status;
    logic [15:0] tag;
    logic [32:0] sec;
    logic [19:0] usec;
    logic        last;
  } fired_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic s_tuser = 1'b0;
  logic [119:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic m_tuser;
  logic [71:0] m_tdata;
  logic m_tlast;

  // Predictor state: heap of due times and the last tick time.
  logic [32:0] hp_sec [Capacity];
  logic [19:0] hp_usec [Capacity];
  logic [15:0] hp_tag [Capacity];
  int hp_count = 0;
  logic [31:0] now_s = '0;
  logic [19:0] now_u = '0;

  fired_t expected_fires[$];
  int errors = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_cycles = 0;
  int stall_left = 0;
  int quiet = 0;

  timed_event_min_heap_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit slot_earlier(int a, int b);
    return (hp_sec[a] < hp_sec[b]) || (hp_sec[a] == hp_sec[b] && hp_usec[a] < hp_usec[b]);
  endfunction

  function automatic void slot_swap(int a, int b);
    logic [32:0] s;
    logic [19:0] u;
    logic [15:0] t;
    s = hp_sec[a]; u = hp_usec[a]; t = hp_tag[a];
    hp_sec[a] = hp_sec[b]; hp_usec[a] = hp_usec[b]; hp_tag[a] = hp_tag[b];
    hp_sec[b] = s; hp_usec[b] = u; hp_tag[b] = t;
  endfunction

  // Work out the results of one accepted request and update the heap copy.
  function automatic void predict_timer(logic fn, logic [30:0] osec, logic [19:0] ousec,
                                        logic [15:0] tag, logic [31:0] ns, logic [19:0] nu);
    logic [20:0] sum;
    logic [32:0] dsec;
    logic [19:0] dusec;
    int pos, par, l, r, best, n;
    fired_t f;
    if (fn == FUNC_SCHED) begin
      sum = 21'(now_u) + 21'(ousec);
      dsec = 33'(now_s) + 33'(osec) + 33'(sum / 1000000);
      dusec = 20'(sum % 1000000);
      if (hp_count >= Capacity) begin
        f = '{ST_FULL, tag, dsec, dusec, 1'b1};
        expected_fires.push_back(f);
        return;
      end
      hp_sec[hp_count] = dsec; hp_usec[hp_count] = dusec; hp_tag[hp_count] = tag;
      hp_count++;
      pos = hp_count;
      while (pos > 1) begin
        par = pos / 2;
        if (!slot_earlier(pos - 1, par - 1)) break;
        slot_swap(pos - 1, par - 1);
        pos = par;
      end
    end else begin
      n = 0;
      now_s = ns;
      now_u = nu;
      while (hp_count > 0) begin
        if (!(33'(now_s) > hp_sec[0] || (33'(now_s) == hp_sec[0] && now_u > hp_usec[0])))
          break;
        f = '{ST_FIRED, hp_tag[0], hp_sec[0], hp_usec[0], 1'b0};
        expected_fires.push_back(f);
        n++;
        hp_count--;
        if (hp_count > 0) begin
          hp_sec[0] = hp_sec[hp_count]; hp_usec[0] = hp_usec[hp_count];
          hp_tag[0] = hp_tag[hp_count];
          pos = 1;
          forever begin
            l = 2 * pos; r = l + 1; best = pos;
            if (l <= hp_count && slot_earlier(l - 1, pos - 1)) best = l;
            if (r <= hp_count && slot_earlier(r - 1, best - 1)) best = r;
            if (best == pos) break;
            slot_swap(pos - 1, best - 1);
            pos = best;
          end
        end
      end
      if (n > 0) begin
        f = expected_fires.pop_back();
        f.last = 1'b1;
        expected_fires.push_back(f);
      end
    end
  endfunction

  // Send one request, with random gaps before it while idling is on.
  task automatic send_request(logic fn, logic [30:0] osec, logic [19:0] ousec,
                              logic [15:0] tag, logic [31:0] ns, logic [19:0] nu);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {1'b0, nu, ns, tag, ousec, osec};
    do @(posedge clk); while (!s_tready);
    predict_timer(fn, osec, ousec, tag, ns, nu);
  endtask

  task automatic schedule(logic [30:0] osec, logic [19:0] ousec, logic [15:0] tag);
    send_request(FUNC_SCHED, osec, ousec, tag, $urandom, 20'($urandom));
  endtask

  task automatic tick(logic [31:0] ns, logic [19:0] nu);
    send_request(FUNC_TICK, 31'($urandom), 20'($urandom), 16'($urandom), ns, nu);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_fires.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Field extremes, carries, ties and nothing expired.
  task automatic test_directed();
    tick(32'd0, 20'd0);
    schedule(31'd0, 20'd999999, 16'h0000);
    schedule(31'h7FFFFFFF, 20'd999999, 16'hFFFF);
    schedule(31'd5, 20'd0, 16'h1234);
    schedule(31'd5, 20'd0, 16'h4321);
    schedule(31'd3, 20'd500000, 16'hA5A5);
    tick(32'd4, 20'd0);
    tick(32'd5, 20'd0);
    tick(32'd5, 20'd1);
    tick(32'hFFFFFFFF, 20'hFFFFF);
    schedule(31'h7FFFFFFF, 20'd999999, 16'h5A5A);
    schedule(31'd1, 20'hFFFFF, 16'h0F0F);
    tick(32'hFFFFFFFF, 20'd999999);
    tick(32'd0, 20'd0);
    schedule(31'd0, 20'd0, 16'h00FF);
    tick(32'd0, 20'd0);
    tick(32'd0, 20'd1);
    wait_drained();
  endtask

  // Overfill the heap while the receiver holds off, then drain it in one tick.
  task automatic test_queue_full();
    int i;
    tick(32'd100, 20'd0);
    for (i = 0; i < Capacity + 3; i++) begin
      if (i == Capacity) hold_req = 1'b1;
      schedule(31'($urandom_range(0, 20)), 20'($urandom_range(0, 999999)), 16'($urandom));
    end
    tick(32'hFFFFFFFF, 20'hFFFFF);
    for (i = 0; i < 4; i++) schedule(31'd1, 20'd0, 16'($urandom));
    wait_drained();
  endtask

  // Mostly near-term random schedules with occasional ticks, most of them advancing the time.
  task automatic test_random(int count);
    int i;
    logic [31:0] t;
    t = 32'd1000;
    tick(t, 20'd0);
    for (i = 0; i < count; i++) begin
      if (i == count - 25) idle_on = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        t = t + $urandom_range(0, 6);
        tick($urandom_range(0, 15) == 0 ? $urandom : t, 20'($urandom));
      end else if ($urandom_range(0, 9) == 0) begin
        schedule(31'($urandom), 20'($urandom), 16'($urandom));
      end else begin
        schedule(31'($urandom_range(0, 8)), 20'($urandom_range(0, 999999)), 16'($urandom));
      end
    end
    tick(t + 32'd100, 20'd0);
    wait_drained();
  endtask

  // Receiver: short random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cycles <= 300;
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(1, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    fired_t got, exp_f;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[15:0], m_tdata[48:16], m_tdata[68:49], m_tlast};
      if (expected_fires.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_f = expected_fires.pop_front();
        if (got.status !== exp_f.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_f.status, got.status);
        if (got.tag !== exp_f.tag)
          $display("%0t: tag expected %h actual %h", $time, exp_f.tag, got.tag);
        if (got.sec !== exp_f.sec)
          $display("%0t: due_sec expected %0d actual %0d", $time, exp_f.sec, got.sec);
        if (got.usec !== exp_f.usec)
          $display("%0t: due_usec expected %0d actual %0d", $time, exp_f.usec, got.usec);
        if (got.last !== exp_f.last)
          $display("%0t: last expected %0d actual %0d", $time, exp_f.last, got.last);
        if (got !== exp_f) errors++;
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_queue_full();
    test_random(40);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== timed_event_min_heap_core.f =====
hdl/temh_pkg.sv
hdl/temh_datapath.sv
hdl/temh_ctrl.sv
hdl/timed_event_min_heap_core.sv
sim/timed_event_min_heap_core_tb.sv
